FILE: src/stop_and_wait_firmware_sender_assert.svh
// Assertion macros used by the checker file.
`ifndef STOP_AND_WAIT_FIRMWARE_SENDER_ASSERT_SVH
`define STOP_AND_WAIT_FIRMWARE_SENDER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define SWS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define SWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sws_pkg.sv
`default_nettype none

package sws_pkg;

    localparam int PAYLOAD_BYTES = 64;

    localparam int FSIZE_W  = 22;
    localparam int TMO_W    = 16;
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 7;
    localparam int CRC16_W  = 16;
    localparam int CRC32_W  = 32;
    localparam int PASS_W   = 23;
    localparam int ACKS_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'b1;

    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd1280;
    localparam logic [CRC16_W-1:0] CRC16_INIT    = 16'hFFFF;
    localparam logic [CRC16_W-1:0] CRC16_POLY    = 16'h1021;
    localparam logic [CRC32_W-1:0] CRC32_POLY    = 32'hEDB88320;
    localparam logic [LEN_W-1:0]   LEN_FULL      = LEN_W'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        MODE_CRC_BYTE = 2'd0,
        MODE_PAY_BYTE = 2'd1,
        MODE_ACK      = 2'd2,
        MODE_TICK     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_RESEND = 3'd1,
        KIND_NEXT   = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_CRC32  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PTYPE_DATA  = 2'd0,
        PTYPE_START = 2'd1,
        PTYPE_END   = 2'd2
    } ptype_t;

    typedef enum logic [1:0] {
        PH_CRC     = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_WAIT    = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    // Classified word as it travels through the queue.
    typedef struct packed {
        mode_t            mode;
        logic [7:0]       data_byte;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_good;
    } qword_t;

    typedef struct packed {
        logic [FSIZE_W-1:0] file_size;
        logic [TMO_W-1:0]   timeout_ticks;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [SEQ_W-1:0]   packet_number;
        logic [SEQ_W-1:0]   total_packets;
        logic [LEN_W-1:0]   payload_length;
        logic [CRC16_W-1:0] packet_crc;
        logic [FSIZE_W-1:0] flash_offset;
        ptype_t             packet_type;
        logic [CRC32_W-1:0] extra_word;
    } result_t;

endpackage

`default_nettype wire

FILE: src/sws_front.sv
`default_nettype none

// Accept and classify input words; hold them in a two-entry queue.
module sws_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic [7:0]                data_byte,
    input  logic [sws_pkg::SEQ_W-1:0] ack_number,
    input  logic [sws_pkg::ACKS_W-1:0] ack_status,
    input  logic                      ack_size_ok,
    input  logic                      pop,
    output logic                      q_valid,
    output sws_pkg::qword_t           q_word
);

    sws_pkg::qword_t ent_reg [2];
    sws_pkg::qword_t word_in;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            do_pop;

    always_comb
    begin
        word_in.mode       = sws_pkg::mode_t'(mode);
        word_in.data_byte  = data_byte;
        word_in.ack_number = ack_number;
        // only a well-sized, clean acknowledge can ever match
        word_in.ack_good   = ack_size_ok && (ack_status == '0);
    end

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = ent_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule

`default_nettype wire

FILE: src/sws_back.sv
`default_nettype none

// Carry out one queued word per cycle when the output is ready: CRC folds, framing, ack and timeout.
module sws_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sws_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  sws_pkg::qword_t      q_word,
    output logic                 pop,
    input  logic                 res_ready,
    output logic                 res_load,
    output sws_pkg::result_t     res
);

    function automatic logic [sws_pkg::CRC32_W-1:0] crc32_byte(
        input logic [sws_pkg::CRC32_W-1:0] crc,
        input logic [7:0]                  b
    );
        logic [sws_pkg::CRC32_W-1:0] c;
        int j;
        c = ~crc ^ {24'b0, b};
        for (j = 0; j < 8; j++)
        begin
            c = (c >> 1) ^ (sws_pkg::CRC32_POLY & {sws_pkg::CRC32_W{c[0]}});
        end
        return ~c;
    endfunction

    function automatic logic [sws_pkg::CRC16_W-1:0] crc16_byte(
        input logic [sws_pkg::CRC16_W-1:0] crc,
        input logic [7:0]                  b
    );
        logic [sws_pkg::CRC16_W-1:0] c;
        int j;
        c = crc ^ {b, 8'b0};
        for (j = 0; j < 8; j++)
        begin
            c = c[15] ? ((c << 1) ^ sws_pkg::CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [sws_pkg::LEN_W-1:0] length_for(
        input logic [sws_pkg::SEQ_W-1:0]   s,
        input logic [sws_pkg::SEQ_W-1:0]   cnt,
        input logic [sws_pkg::FSIZE_W-1:0] fs
    );
        logic [sws_pkg::LEN_W-1:0] rem;
        rem = sws_pkg::LEN_W'(fs % sws_pkg::PAYLOAD_BYTES);
        if (cnt != '0 && s == cnt - 16'd1 && rem != '0)
        begin
            return rem;
        end
        return sws_pkg::LEN_FULL;
    endfunction

    // Build a packet-bearing result: offset, type and extra word follow s.
    function automatic sws_pkg::result_t pkt_result(
        input sws_pkg::kind_t              k,
        input logic [sws_pkg::SEQ_W-1:0]   s,
        input logic [sws_pkg::SEQ_W-1:0]   cnt,
        input logic [sws_pkg::FSIZE_W-1:0] fs,
        input logic [sws_pkg::CRC32_W-1:0] fcrc,
        input logic [sws_pkg::LEN_W-1:0]   len,
        input logic [sws_pkg::CRC16_W-1:0] crc
    );
        sws_pkg::result_t r;
        sws_pkg::ptype_t  t;
        if (s == '0)
        begin
            t = sws_pkg::PTYPE_START;
        end
        else if (cnt != '0 && s == cnt - 16'd1)
        begin
            t = sws_pkg::PTYPE_END;
        end
        else
        begin
            t = sws_pkg::PTYPE_DATA;
        end
        r.kind           = k;
        r.packet_number  = s;
        r.total_packets  = cnt;
        r.payload_length = len;
        r.packet_crc     = crc;
        r.flash_offset   = sws_pkg::FSIZE_W'(32'(s) * sws_pkg::PAYLOAD_BYTES);
        r.packet_type    = t;
        if (t == sws_pkg::PTYPE_START)
        begin
            r.extra_word = sws_pkg::CRC32_W'(fs);
        end
        else if (t == sws_pkg::PTYPE_END)
        begin
            r.extra_word = fcrc;
        end
        else
        begin
            r.extra_word = '0;
        end
        return r;
    endfunction

    sws_pkg::phase_t               phase_reg, phase_next;
    logic [sws_pkg::SEQ_W-1:0]     seq_reg, seq_next;
    logic [sws_pkg::SEQ_W-1:0]     count_reg, count_next;
    logic [sws_pkg::CRC32_W-1:0]   fcrc_reg, fcrc_next;
    logic [sws_pkg::PASS_W-1:0]    pass_reg, pass_next;
    logic [sws_pkg::LEN_W-1:0]     pay_reg, pay_next;
    logic [sws_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [sws_pkg::CRC16_W-1:0]   crc16_reg, crc16_next;
    logic [sws_pkg::TMO_W-1:0]     wait_reg, wait_next;

    logic                          fire;
    logic [sws_pkg::CRC32_W-1:0]   crc32_upd, crc32_new;
    logic [sws_pkg::CRC16_W-1:0]   crc16_upd;
    logic [sws_pkg::PASS_W-1:0]    pass_new;
    logic [16:0]                   n_raw;
    logic [sws_pkg::SEQ_W-1:0]     count_calc;
    logic [sws_pkg::LEN_W-1:0]     pay_inc;
    logic [sws_pkg::SEQ_W-1:0]     seq_inc;
    logic [sws_pkg::TMO_W-1:0]     wait_inc;
    logic                          crc_fold, crc_end, empty_done;
    logic                          pay_fold, pay_last;
    logic                          ack_hit, ack_done, ack_next, tick, tmo;

    assign fire = q_valid && res_ready;
    assign pop  = fire;

    // Shared datapath and event classification against the current phase.
    always_comb
    begin
        crc32_upd  = crc32_byte(fcrc_reg, q_word.data_byte);
        crc16_upd  = crc16_byte(crc16_reg, q_word.data_byte);
        pay_inc    = pay_reg + 7'd1;
        seq_inc    = seq_reg + 16'd1;
        wait_inc   = wait_reg + 16'd1;
        n_raw      = 17'(cfg.file_size / sws_pkg::PAYLOAD_BYTES)
                   + 17'((cfg.file_size % sws_pkg::PAYLOAD_BYTES) != 0);
        count_calc = n_raw[16] ? 16'hFFFF : n_raw[15:0];

        crc_fold   = (phase_reg == sws_pkg::PH_CRC)
                   && (pass_reg < {1'b0, cfg.file_size})
                   && (q_word.mode == sws_pkg::MODE_CRC_BYTE);
        pass_new   = crc_fold ? pass_reg + 23'd1 : pass_reg;
        crc32_new  = crc_fold ? crc32_upd : fcrc_reg;
        crc_end    = (phase_reg == sws_pkg::PH_CRC) && (pass_new >= {1'b0, cfg.file_size});

        empty_done = (phase_reg == sws_pkg::PH_PAYLOAD) && (seq_reg >= count_reg);
        pay_fold   = (phase_reg == sws_pkg::PH_PAYLOAD) && !empty_done
                   && (q_word.mode == sws_pkg::MODE_PAY_BYTE);
        pay_last   = pay_fold && (pay_inc >= len_reg);

        ack_hit    = (phase_reg == sws_pkg::PH_WAIT) && (q_word.mode == sws_pkg::MODE_ACK)
                   && q_word.ack_good && (q_word.ack_number == seq_reg);
        ack_done   = ack_hit && (seq_inc >= count_reg);
        ack_next   = ack_hit && !ack_done;
        tick       = (phase_reg == sws_pkg::PH_WAIT) && (q_word.mode == sws_pkg::MODE_TICK);
        tmo        = tick && ((wait_inc >= cfg.timeout_ticks) || (wait_inc == '0));
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        fcrc_next  = fcrc_reg;
        pass_next  = pass_reg;
        pay_next   = pay_reg;
        len_next   = len_reg;
        crc16_next = crc16_reg;
        wait_next  = wait_reg;
        if (fire)
        begin
            case (phase_reg)
                sws_pkg::PH_CRC:
                begin
                    fcrc_next = crc32_new;
                    pass_next = pass_new;
                    if (crc_end)
                    begin
                        count_next = count_calc;
                        seq_next   = '0;
                        pay_next   = '0;
                        crc16_next = sws_pkg::CRC16_INIT;
                        len_next   = length_for('0, count_calc, cfg.file_size);
                        wait_next  = '0;
                        phase_next = sws_pkg::PH_PAYLOAD;
                    end
                end
                sws_pkg::PH_PAYLOAD:
                begin
                    if (empty_done)
                    begin
                        phase_next = sws_pkg::PH_DONE;
                    end
                    else if (pay_fold)
                    begin
                        crc16_next = crc16_upd;
                        pay_next   = pay_inc;
                        if (pay_last)
                        begin
                            wait_next  = '0;
                            phase_next = sws_pkg::PH_WAIT;
                        end
                    end
                end
                sws_pkg::PH_WAIT:
                begin
                    if (ack_done)
                    begin
                        seq_next   = seq_inc;
                        phase_next = sws_pkg::PH_DONE;
                    end
                    else if (ack_next || tmo)
                    begin
                        // restart framing; a resend keeps the sequence
                        seq_next   = ack_next ? seq_inc : seq_reg;
                        pay_next   = '0;
                        crc16_next = sws_pkg::CRC16_INIT;
                        len_next   = length_for(ack_next ? seq_inc : seq_reg, count_reg,
                                                cfg.file_size);
                        wait_next  = '0;
                        phase_next = sws_pkg::PH_PAYLOAD;
                    end
                    else if (tick)
                    begin
                        wait_next = wait_inc;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result word.
    always_comb
    begin
        res_load = 1'b0;
        res      = '0;
        if (crc_end)
        begin
            res_load          = fire;
            res.kind          = sws_pkg::KIND_CRC32;
            res.total_packets = count_calc;
            res.extra_word    = crc32_new;
        end
        else if (empty_done || ack_done)
        begin
            res_load          = fire;
            res.kind          = sws_pkg::KIND_DONE;
            res.packet_number = ack_done ? seq_inc : seq_reg;
            res.total_packets = count_reg;
        end
        else if (pay_last)
        begin
            res_load = fire;
            res      = pkt_result(sws_pkg::KIND_HEADER, seq_reg, count_reg, cfg.file_size,
                                  fcrc_reg, len_reg, crc16_upd);
        end
        else if (ack_next)
        begin
            res_load = fire;
            res      = pkt_result(sws_pkg::KIND_NEXT, seq_inc, count_reg, cfg.file_size,
                                  fcrc_reg, length_for(seq_inc, count_reg, cfg.file_size),
                                  '0);
        end
        else if (tmo)
        begin
            res_load = fire;
            res      = pkt_result(sws_pkg::KIND_RESEND, seq_reg, count_reg, cfg.file_size,
                                  fcrc_reg, length_for(seq_reg, count_reg, cfg.file_size),
                                  '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sws_pkg::PH_CRC;
            seq_reg   <= '0;
            count_reg <= '0;
            fcrc_reg  <= '0;
            pass_reg  <= '0;
            pay_reg   <= '0;
            len_reg   <= '0;
            crc16_reg <= sws_pkg::CRC16_INIT;
            wait_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            fcrc_reg  <= fcrc_next;
            pass_reg  <= pass_next;
            pay_reg   <= pay_next;
            len_reg   <= len_next;
            crc16_reg <= crc16_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sws_out.sv
`default_nettype none

// Output register: hold a result word until the sink takes it.
module sws_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sws_pkg::result_t res_in,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_stall,
    output sws_pkg::result_t res_out
);

    logic             valid_reg, valid_next;
    sws_pkg::result_t data_reg;

    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_comb
    begin
        valid_next = ready ? load : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

FILE: src/stop_and_wait_firmware_sender.sv
`default_nettype none

// Stop-and-wait image sender. Feed one word per clock: first the image bytes
// (mode 0) for the CRC-32 pass, which ends in a crc32-ready result; then per
// packet the payload bytes (mode 1), which end in a header-ready result with
// the CRC-16/CCITT, offset, length, type and extra word; then acknowledges
// (mode 2) and timer ticks (mode 3), which give next-packet, resend or
// complete. Words that do not fit the current phase are dropped without a
// result. Throughput is one input word per clock while the output is not
// stalled, set by the back end, which retires one queued word per cycle
// with a bytewise CRC update whenever the output register can take a result.
// An accepted word lands in the two-word input queue, and the back end loads
// its result into the output register when it takes the word from the queue.
// in_stall rises only when the queue is full, which happens only while the
// output register is held by out_stall. Write file_size and timeout_ticks
// only while the block is idle; a timeout of 0 behaves as 1.
module stop_and_wait_firmware_sender (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  logic [sws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     data_byte,
    input  logic [sws_pkg::SEQ_W-1:0]      ack_number,
    input  logic [sws_pkg::ACKS_W-1:0]     ack_status,
    input  logic                           ack_size_ok,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     kind,
    output logic [sws_pkg::SEQ_W-1:0]      packet_number,
    output logic [sws_pkg::SEQ_W-1:0]      total_packets,
    output logic [sws_pkg::LEN_W-1:0]      payload_length,
    output logic [sws_pkg::CRC16_W-1:0]    packet_crc,
    output logic [sws_pkg::FSIZE_W-1:0]    flash_offset,
    output logic [1:0]                     packet_type,
    output logic [sws_pkg::CRC32_W-1:0]    extra_word
);

    logic [sws_pkg::FSIZE_W-1:0] fsize_reg, fsize_next;
    logic [sws_pkg::TMO_W-1:0]   tmo_reg, tmo_next;
    sws_pkg::cfg_t               cfg;

    logic                        q_valid;
    sws_pkg::qword_t             q_word;
    logic                        pop;
    logic                        res_ready;
    logic                        res_load;
    sws_pkg::result_t            res;
    sws_pkg::result_t            res_out;

    // Configuration registers.
    always_comb
    begin
        fsize_next = fsize_reg;
        tmo_next   = tmo_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sws_pkg::CFG_FILE_SIZE: fsize_next = cfg_data;
                sws_pkg::CFG_TIMEOUT:   tmo_next   = cfg_data[sws_pkg::TMO_W-1:0];
                default:                tmo_next   = tmo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsize_reg <= '0;
            tmo_reg   <= sws_pkg::TIMEOUT_RESET;
        end
        else
        begin
            fsize_reg <= fsize_next;
            tmo_reg   <= tmo_next;
        end
    end

    assign cfg.file_size     = fsize_reg;
    assign cfg.timeout_ticks = tmo_reg;

    // Front end: classify and queue.
    sws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .ack_number  (ack_number),
        .ack_status  (ack_status),
        .ack_size_ok (ack_size_ok),
        .pop         (pop),
        .q_valid     (q_valid),
        .q_word      (q_word)
    );

    // Back end: advance the transfer state one word per cycle while the output is ready.
    sws_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .pop       (pop),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    // Output register toward the sink.
    sws_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res_in    (res),
        .ready     (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign kind           = res_out.kind;
    assign packet_number  = res_out.packet_number;
    assign total_packets  = res_out.total_packets;
    assign payload_length = res_out.payload_length;
    assign packet_crc     = res_out.packet_crc;
    assign flash_offset   = res_out.flash_offset;
    assign packet_type    = res_out.packet_type;
    assign extra_word     = res_out.extra_word;

endmodule

`default_nettype wire

FILE: src/sws_checker.sv
`default_nettype none

`include "stop_and_wait_firmware_sender_assert.svh"

// Port-level checks on the result stream.
module sws_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] packet_number,
    input  logic [15:0] total_packets,
    input  logic [6:0]  payload_length,
    input  logic [15:0] packet_crc,
    input  logic [21:0] flash_offset,
    input  logic [1:0]  packet_type,
    input  logic [31:0] extra_word
);

    `SWS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(extra_word) && $stable(packet_number) && $stable(kind), "stalled result word changed")
    `SWS_ASSERT_IMPLY(a_crc32_bare, out_valid && (kind == sws_pkg::KIND_CRC32), (payload_length == 7'd0) && (packet_crc == 16'd0) && (flash_offset == 22'd0) && (packet_type == sws_pkg::PTYPE_DATA), "crc32 word carries packet fields")
    `SWS_ASSERT_IMPLY(a_done_seq, out_valid && (kind == sws_pkg::KIND_DONE), packet_number >= total_packets, "complete before last packet")
    `SWS_ASSERT_IMPLY(a_start_zero, out_valid && (packet_type == sws_pkg::PTYPE_START), packet_number == 16'd0, "start type on nonzero packet")
    `SWS_ASSERT_IMPLY(a_hdr_len, out_valid && (kind == sws_pkg::KIND_HEADER), (payload_length != 7'd0) && (payload_length <= sws_pkg::LEN_FULL), "header length out of range")

endmodule

bind stop_and_wait_firmware_sender sws_checker u_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import sws_pkg::*;

    // Clock, reset and block ports. Start every input at a known value.
    logic                  clk;
    logic                  rst_n = 1'b0;

    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode = '0;
    logic [7:0]            data_byte = '0;
    logic [SEQ_W-1:0]      ack_number = '0;
    logic [ACKS_W-1:0]     ack_status = '0;
    logic                  ack_size_ok = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            kind;
    logic [SEQ_W-1:0]      packet_number;
    logic [SEQ_W-1:0]      total_packets;
    logic [LEN_W-1:0]      payload_length;
    logic [CRC16_W-1:0]    packet_crc;
    logic [FSIZE_W-1:0]    flash_offset;
    logic [1:0]            packet_type;
    logic [CRC32_W-1:0]    extra_word;

    stop_and_wait_firmware_sender dut (.*);

    // Sender state as the testbench sees it: register copies plus the
    // transfer state, advanced once per accepted word.
    logic [FSIZE_W-1:0]  cfg_size;
    logic [TMO_W-1:0]    cfg_ticks;
    logic [SEQ_W-1:0]    seq_no;
    logic [SEQ_W-1:0]    pkt_total;
    logic [CRC32_W-1:0]  img_crc;
    logic [PASS_W-1:0]   pass_count;
    logic [LEN_W-1:0]    pay_count;
    logic [LEN_W-1:0]    cur_len;
    logic [CRC16_W-1:0]  pkt_crc16;
    logic [TMO_W-1:0]    tick_count;
    phase_t              ph;

    // Reports the sender owes us, oldest first.
    result_t due_reports[$];

    int errors;
    int words_sent;
    int reports_checked;
    int resends_seen;
    int in_stall_cycles;
    int image_len;
    bit tx_steady;
    int rx_hold_request;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run far beyond the slowest legal pacing.
    initial
    begin
        #3_000_000;
        $display("stop_and_wait_firmware_sender test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender behavior
    // ------------------------------------------------------------------
    function automatic logic [CRC32_W-1:0] crc32_fold(logic [CRC32_W-1:0] crc, logic [7:0] b);
        logic [CRC32_W-1:0] c;
        c = ~crc ^ {24'd0, b};
        for (int j = 0; j < 8; j++)
            c = (c >> 1) ^ (c[0] ? CRC32_POLY : '0);
        return ~c;
    endfunction

    function automatic logic [CRC16_W-1:0] crc16_fold(logic [CRC16_W-1:0] crc, logic [7:0] b);
        logic [CRC16_W-1:0] c;
        c = crc ^ {b, 8'd0};
        for (int j = 0; j < 8; j++)
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        return c;
    endfunction

    // Last packet carries the remainder, or a full payload when it divides evenly.
    function automatic logic [LEN_W-1:0] length_of(logic [SEQ_W-1:0] s);
        int rem;
        rem = cfg_size % PAYLOAD_BYTES;
        if (pkt_total != 0 && s == pkt_total - 16'd1 && rem != 0)
            return LEN_W'(rem);
        return LEN_W'(PAYLOAD_BYTES);
    endfunction

    function automatic void open_packet();
        pay_count  = '0;
        pkt_crc16  = CRC16_INIT;
        cur_len    = length_of(seq_no);
        tick_count = '0;
        ph         = PH_PAYLOAD;
    endfunction

    function automatic result_t make_report(kind_t k, logic [LEN_W-1:0] len,
                                            logic [CRC16_W-1:0] crc, bit pkt);
        result_t r;
        ptype_t  t;
        t = PTYPE_DATA;
        if (pkt && seq_no == 0)
            t = PTYPE_START;
        else if (pkt && pkt_total != 0 && seq_no == pkt_total - 16'd1)
            t = PTYPE_END;
        r.kind           = k;
        r.packet_number  = seq_no;
        r.total_packets  = pkt_total;
        r.payload_length = len;
        r.packet_crc     = crc;
        r.flash_offset   = pkt ? FSIZE_W'(32'(seq_no) * PAYLOAD_BYTES) : '0;
        r.packet_type    = t;
        if (k == KIND_CRC32 || t == PTYPE_END)
            r.extra_word = img_crc;
        else if (t == PTYPE_START)
            r.extra_word = CRC32_W'(cfg_size);
        else
            r.extra_word = '0;
        return r;
    endfunction

    // Advance the sender by one word; return 1 with the report it owes.
    function automatic bit advance_sender(mode_t m, logic [7:0] b, logic [SEQ_W-1:0] an,
                                          logic [ACKS_W-1:0] as, logic ok,
                                          output result_t r);
        longint n;
        r = '0;
        case (ph)
            PH_CRC:
            begin
                if (pass_count < cfg_size && m == MODE_CRC_BYTE)
                begin
                    img_crc    = crc32_fold(img_crc, b);
                    pass_count = pass_count + 1'b1;
                end
                if (pass_count >= cfg_size)
                begin
                    n = (longint'(cfg_size) + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
                    pkt_total = (n > 65535) ? 16'hFFFF : SEQ_W'(n);
                    seq_no = '0;
                    open_packet();
                    r = make_report(KIND_CRC32, '0, '0, 1'b0);
                    return 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                // Empty image: nothing to send, report completion at once.
                if (seq_no >= pkt_total)
                begin
                    ph = PH_DONE;
                    r = make_report(KIND_DONE, '0, '0, 1'b0);
                    return 1'b1;
                end
                if (m == MODE_PAY_BYTE)
                begin
                    pkt_crc16 = crc16_fold(pkt_crc16, b);
                    pay_count = pay_count + 1'b1;
                    if (pay_count >= cur_len)
                    begin
                        ph = PH_WAIT;
                        tick_count = '0;
                        r = make_report(KIND_HEADER, cur_len, pkt_crc16, 1'b1);
                        return 1'b1;
                    end
                end
            end
            PH_WAIT:
            begin
                if (m == MODE_ACK && ok && an == seq_no && as == 0)
                begin
                    seq_no = seq_no + 1'b1;
                    if (seq_no >= pkt_total)
                    begin
                        ph = PH_DONE;
                        r = make_report(KIND_DONE, '0, '0, 1'b0);
                        return 1'b1;
                    end
                    open_packet();
                    r = make_report(KIND_NEXT, cur_len, '0, 1'b1);
                    return 1'b1;
                end
                if (m == MODE_TICK)
                begin
                    // A zero timeout fires on the first tick, as does a wrapped count.
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= cfg_ticks || tick_count == 0)
                    begin
                        open_packet();
                        r = make_report(KIND_RESEND, cur_len, '0, 1'b1);
                        return 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Drive side
    // ------------------------------------------------------------------

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Offer one word, hold it until accepted, then advance the expected state.
    task automatic send_word(mode_t m, logic [7:0] b, logic [SEQ_W-1:0] an,
                             logic [ACKS_W-1:0] as, logic ok);
        int      gap;
        result_t r;
        if ($urandom_range(0, 99) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        data_byte   <= b;
        ack_number  <= an;
        ack_status  <= as;
        ack_size_ok <= ok;
        @(posedge clk);
        while (in_stall)
        begin
            in_stall_cycles++;
            @(posedge clk);
        end
        words_sent++;
        if (advance_sender(m, b, an, as, ok, r))
            due_reports.push_back(r);
    endtask

    task automatic send_random(mode_t m);
        send_word(m, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_good_ack();
        send_word(MODE_ACK, 8'($urandom), seq_no, 8'd0, 1'b1);
    endtask

    // Acknowledge that must not match: wrong number, bad status or bad size.
    task automatic send_bad_ack();
        logic [SEQ_W-1:0]  n;
        logic [ACKS_W-1:0] s;
        logic              ok;
        n  = seq_no;
        s  = '0;
        ok = 1'b1;
        case ($urandom_range(0, 3))
            0: n = seq_no ^ 16'($urandom_range(1, 65535));
            1: s = 8'($urandom_range(1, 255));
            2: ok = 1'b0;
            default:
            begin
                n  = 16'($urandom);
                s  = 8'($urandom_range(1, 255));
                ok = 1'($urandom);
            end
        endcase
        send_word(MODE_ACK, 8'($urandom), n, s, ok);
    endtask

    // Drop valid, wait for every owed report, then let in-flight words retire.
    task automatic settle();
        in_valid <= 1'b0;
        for (int w = 0; w < 5000 && due_reports.size() != 0; w++)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_FILE_SIZE)
            cfg_size = FSIZE_W'(value);
        else
            cfg_ticks = TMO_W'(value);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receive side: random stall, forced long hold, and the report check
    // ------------------------------------------------------------------
    function automatic string describe(result_t r);
        return $sformatf("kind=%0d pkt=%0d total=%0d len=%0d crc=%h off=%0d type=%0d extra=%h",
                         r.kind, r.packet_number, r.total_packets, r.payload_length,
                         r.packet_crc, r.flash_offset, r.packet_type, r.extra_word);
    endfunction

    task automatic log_failure(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_report();
        result_t got;
        result_t want;
        got.kind           = kind_t'(kind);
        got.packet_number  = packet_number;
        got.total_packets  = total_packets;
        got.payload_length = payload_length;
        got.packet_crc     = packet_crc;
        got.flash_offset   = flash_offset;
        got.packet_type    = ptype_t'(packet_type);
        got.extra_word     = extra_word;
        reports_checked++;
        if (got.kind == KIND_RESEND)
            resends_seen++;
        if (due_reports.size() == 0)
        begin
            log_failure({"unexpected report: ", describe(got)});
            return;
        end
        want = due_reports.pop_front();
        if (got.kind !== want.kind || got.packet_number !== want.packet_number ||
            got.total_packets !== want.total_packets ||
            got.payload_length !== want.payload_length ||
            got.packet_crc !== want.packet_crc || got.flash_offset !== want.flash_offset ||
            got.packet_type !== want.packet_type || got.extra_word !== want.extra_word)
            log_failure({"expected ", describe(want), "\n           actual   ", describe(got)});
    endtask

    initial
    begin : receive_side
        int hold_left;
        int run_left;
        hold_left = 0;
        run_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_report();
            if (rx_hold_request > 0)
            begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            // A forced hold overrides the random pattern and is counted here.
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (run_left > 0)
                run_left--;
            else if (out_stall || $urandom_range(0, 99) < 60)
            begin
                out_stall <= 1'b0;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(0, 12);
            end
            else
            begin
                out_stall <= 1'b1;
                run_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // CRC-32 pass: extremes and stray words first, then random image bytes.
    // Hold file_size at 4194240 during the pass and bring it down to the
    // image length just before the last three bytes, so the pass ends on a byte.
    task automatic test_crc_pass();
        write_reg(CFG_FILE_SIZE, 4194240);
        write_reg(CFG_TIMEOUT, 65535);
        image_len = $urandom_range(600, 700);
        if (image_len % PAYLOAD_BYTES == 0)
            image_len++;

        send_word(MODE_CRC_BYTE, 8'h00, 16'h0000, 8'h00, 1'b0);
        send_word(MODE_CRC_BYTE, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
        send_word(MODE_PAY_BYTE, 8'hFF, 16'h0000, 8'h00, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'hFFFF, 8'hFF, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'h0000, 8'h00, 1'b1);
        send_word(MODE_TICK, 8'hA5, 16'h5A5A, 8'h01, 1'b0);

        while (pass_count < image_len - 3)
        begin
            if ($urandom_range(0, 99) < 8)
                send_random(mode_t'($urandom_range(0, 3)));
            else
                send_random(MODE_CRC_BYTE);
        end
        settle();
        write_reg(CFG_FILE_SIZE, image_len);
        while (ph == PH_CRC)
            send_random(MODE_CRC_BYTE);
        settle();
    endtask

    // Packet 0: extremes of the payload, words out of phase, acknowledges
    // that do not match, a long timeout that does not fire, then a zero
    // timeout under a long receiver hold so the input backs up.
    task automatic test_first_packet();
        send_word(MODE_PAY_BYTE, 8'h00, 16'hFFFF, 8'hFF, 1'b0);
        send_word(MODE_PAY_BYTE, 8'hFF, 16'h0000, 8'h00, 1'b1);
        send_word(MODE_TICK, 8'h00, 16'h0000, 8'h00, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'h0000, 8'h00, 1'b1);
        send_word(MODE_CRC_BYTE, 8'h80, 16'h0000, 8'h00, 1'b1);
        while (ph == PH_PAYLOAD)
            send_random(MODE_PAY_BYTE);

        // Timeout is 65535 here: these ticks must not fire.
        repeat (4) send_random(MODE_TICK);
        send_word(MODE_ACK, 8'h00, 16'hFFFF, 8'h00, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'h0000, 8'h01, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'h0000, 8'hFF, 1'b1);
        send_word(MODE_ACK, 8'h00, 16'h0000, 8'h00, 1'b0);
        send_random(MODE_PAY_BYTE);
        send_random(MODE_CRC_BYTE);
        settle();

        // Zero file size late only changes the start word; zero timeout acts as one.
        write_reg(CFG_FILE_SIZE, 0);
        write_reg(CFG_TIMEOUT, 0);
        rx_hold_request = 60;
        tx_steady = 1'b1;
        send_random(MODE_TICK);
        while (ph == PH_PAYLOAD)
            send_random(MODE_PAY_BYTE);
        tx_steady = 1'b0;
        send_random(MODE_TICK);
        while (ph == PH_PAYLOAD)
            send_random(MODE_PAY_BYTE);
        settle();

        write_reg(CFG_FILE_SIZE, 4194240);
        write_reg(CFG_TIMEOUT, 1);
        send_good_ack();
    endtask

    // Middle packets: random bytes with a little noise, then either a clean
    // acknowledge after some stray words or a run of ticks into a resend.
    task automatic test_random_packets();
        bit retry;
        int pick;
        retry = 1'b0;
        while (!(ph == PH_PAYLOAD && seq_no == pkt_total - 16'd1))
        begin
            pick = $urandom_range(0, 99);
            if (ph == PH_PAYLOAD)
            begin
                if (pick < 6)
                    send_random(mode_t'($urandom_range(0, 3)));
                else
                    send_random(MODE_PAY_BYTE);
                if (ph == PH_WAIT)
                    retry = ($urandom_range(0, 99) < 35);
            end
            else if (retry)
            begin
                if (pick < 80)
                    send_random(MODE_TICK);
                else
                    send_bad_ack();
            end
            else if (pick < 45)
            begin
                send_good_ack();
                // Now and then change the timeout between packets.
                if ($urandom_range(0, 99) < 15)
                begin
                    settle();
                    write_reg(CFG_TIMEOUT, $urandom_range(1, 8));
                end
            end
            else if (pick < 70 || 32'(tick_count) + 1 >= (cfg_ticks == 0 ? 1 : cfg_ticks))
            begin
                if (pick < 62)
                    send_bad_ack();
                else
                    send_random(mode_t'($urandom_range(0, 1)));
            end
            else
                send_random(MODE_TICK);
        end
    endtask

    // Last packet: full length while file_size divides evenly, then a resend
    // after restoring the real size, which shortens it to the remainder.
    task automatic test_last_packet();
        while (ph == PH_PAYLOAD)
        begin
            if ($urandom_range(0, 99) < 6)
                send_random(MODE_TICK);
            else
                send_random(MODE_PAY_BYTE);
        end
        send_word(MODE_ACK, 8'h00, seq_no, 8'h00, 1'b0);
        send_word(MODE_ACK, 8'h00, seq_no, 8'h01, 1'b1);
        settle();
        write_reg(CFG_FILE_SIZE, image_len);
        while (ph == PH_WAIT)
            send_random(MODE_TICK);
        while (ph == PH_PAYLOAD)
            send_random(MODE_PAY_BYTE);
        send_bad_ack();
        send_good_ack();
    endtask

    // Done: every word is dropped, a matching acknowledge included.
    task automatic test_done_phase();
        for (int i = 0; i < 24; i++)
            send_random(mode_t'(i % 4));
        send_good_ack();
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        errors          = 0;
        words_sent      = 0;
        reports_checked = 0;
        resends_seen    = 0;
        in_stall_cycles = 0;
        tx_steady       = 1'b0;
        rx_hold_request = 0;

        // Reset values of the expected state.
        cfg_size   = '0;
        cfg_ticks  = TIMEOUT_RESET;
        seq_no     = '0;
        pkt_total  = '0;
        img_crc    = '0;
        pass_count = '0;
        pay_count  = '0;
        cur_len    = '0;
        pkt_crc16  = CRC16_INIT;
        tick_count = '0;
        ph         = PH_CRC;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_crc_pass();
        test_first_packet();
        test_random_packets();
        test_last_packet();
        test_done_phase();

        repeat (10) @(posedge clk);
        errors += due_reports.size();

        $display("covered %0d words: %0d-byte image in %0d packets, %0d reports checked",
                 words_sent, image_len, pkt_total, reports_checked);
        $display("resends %0d, input held off for %0d cycles, %0d mismatches",
                 resends_seen, in_stall_cycles, errors);
        if (errors == 0)
            $display("stop_and_wait_firmware_sender test passed");
        else
            $display("stop_and_wait_firmware_sender test failed");
        $finish;
    end

endmodule
